[hdl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QueueDepth   = 64;
  localparam int PayloadWidth = 32;
  localparam int CountWidth   = $clog2(QueueDepth + 1);

  localparam int PriWidth     = 32;
  localparam int DataWidth    = 32;
  localparam int CmdWidth     = 2;
  localparam int StatusWidth  = 2;
  localparam int WordWidth    = 72;

  localparam logic [CmdWidth-1:0] CmdInsert = 2'd0;
  localparam logic [CmdWidth-1:0] CmdTop    = 2'd1;
  localparam logic [CmdWidth-1:0] CmdPop    = 2'd2;

  localparam logic [StatusWidth-1:0] StDone  = 2'd0;
  localparam logic [StatusWidth-1:0] StEmpty = 2'd1;
  localparam logic [StatusWidth-1:0] StFull  = 2'd2;

  // Broadcast control for every cell of the row.
  typedef struct packed {
    logic                          insert_en;
    logic                          pop_en;
    logic signed [PriWidth-1:0]    new_pri;
    logic [PayloadWidth-1:0]       new_pay;
  } cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                        clk,
  input  cell_ctrl_t                  ctrl,
  input  logic                        is_head,
  input  logic                        valid,
  input  logic                        left_take,
  input  logic signed [PriWidth-1:0]  left_pri,
  input  logic [PayloadWidth-1:0]     left_pay,
  input  logic signed [PriWidth-1:0]  right_pri,
  input  logic [PayloadWidth-1:0]     right_pay,
  output logic                        take,
  output logic signed [PriWidth-1:0]  pri,
  output logic [PayloadWidth-1:0]     pay,
  output logic signed [PriWidth-1:0]  pri_next,
  output logic [PayloadWidth-1:0]     pay_next
);

  // The new entry belongs here or ahead of here. The head keeps ties ahead.
  assign take = !valid || (is_head ? (pri < ctrl.new_pri) : (pri <= ctrl.new_pri));

  always_comb begin
    pri_next = pri;
    pay_next = pay;
    if (ctrl.pop_en) begin
      pri_next = right_pri;
      pay_next = right_pay;
    end else if (ctrl.insert_en && left_take) begin
      pri_next = left_pri;
      pay_next = left_pay;
    end else if (ctrl.insert_en && take) begin
      pri_next = ctrl.new_pri;
      pay_next = ctrl.new_pay;
    end
  end

  always_ff @(posedge clk) begin
    pri <= pri_next;
    pay <= pay_next;
  end

endmodule

[hdl/spq_chain.sv]
`timescale 1ns / 1ps

module spq_chain
  import spq_pkg::*;
(
  input  logic                        clk,
  input  cell_ctrl_t                  ctrl,
  input  logic [CountWidth-1:0]       count,
  output logic signed [PriWidth-1:0]  head_pri_next,
  output logic [PayloadWidth-1:0]     head_pay_next
);

  logic                       take      [QueueDepth];
  logic signed [PriWidth-1:0] pri       [QueueDepth];
  logic [PayloadWidth-1:0]    pay       [QueueDepth];
  logic signed [PriWidth-1:0] pri_next  [QueueDepth];
  logic [PayloadWidth-1:0]    pay_next  [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic                       l_take;
    logic signed [PriWidth-1:0] l_pri;
    logic [PayloadWidth-1:0]    l_pay;
    logic signed [PriWidth-1:0] r_pri;
    logic [PayloadWidth-1:0]    r_pay;
    logic                       cell_valid;

    if (i == 0) begin : g_first
      assign l_take = 1'b0;
      assign l_pri  = '0;
      assign l_pay  = '0;
    end else begin : g_mid
      assign l_take = take[i-1];
      assign l_pri  = pri[i-1];
      assign l_pay  = pay[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign r_pri = '0;
      assign r_pay = '0;
    end else begin : g_inner
      assign r_pri = pri[i+1];
      assign r_pay = pay[i+1];
    end

    assign cell_valid = CountWidth'(i) < count;

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .is_head   (i == 0),
      .valid     (cell_valid),
      .left_take (l_take),
      .left_pri  (l_pri),
      .left_pay  (l_pay),
      .right_pri (r_pri),
      .right_pay (r_pay),
      .take      (take[i]),
      .pri       (pri[i]),
      .pay       (pay[i]),
      .pri_next  (pri_next[i]),
      .pay_next  (pay_next[i])
    );
  end

  assign head_pri_next = pri_next[0];
  assign head_pay_next = pay_next[0];

endmodule

[hdl/sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// Sorted priority queue of (priority, payload) entries, highest priority at
// the head. Input words arrive on s_tvalid/s_tready/s_tdata; each carries a
// command: insert, top (read head) or pop. Every input word yields exactly
// one result word on m_tvalid/m_tready/m_tdata: a status plus the head
// entry as it stands after the command (head fields zero when empty).
// The entries live in a row of cells; each cell compares its priority with
// the broadcast new priority, and on insert the cells from the insert point
// on shift one place away from the head, on pop every cell takes its
// neighbor toward the tail. All cells act in the same cycle, so one word is
// taken every clock; the result appears in the output register in the cycle
// after acceptance. An insert into a full queue is dropped with status full.
// When the receiver stalls, the result holds in the output register and a
// new input word is taken only once that register is free or being read.
// Reset clears the entry count and the output valid; no clearing pass is
// needed, cells beyond the count are never shown.

module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [1:0] command, [33:2] priority_req, [65:34] payload, [71:66] zero
  input  logic [WordWidth-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [1:0] status, [33:2] head_priority, [65:34] head_payload, [71:66] zero
  output logic [WordWidth-1:0] m_tdata
);

  logic [CmdWidth-1:0]         command;
  logic signed [PriWidth-1:0]  priority_req;
  logic [DataWidth-1:0]        payload;
  logic                        accept;
  logic                        empty;
  logic                        full;

  cell_ctrl_t                  ctrl;
  logic [CountWidth-1:0]       count;
  logic [CountWidth-1:0]       count_next;
  logic signed [PriWidth-1:0]  head_pri_next;
  logic [PayloadWidth-1:0]     head_pay_next;

  logic [StatusWidth-1:0]      status;
  logic [StatusWidth-1:0]      status_next;
  logic signed [PriWidth-1:0]  head_priority;
  logic [DataWidth-1:0]        head_payload;

  // Unpack the input word.
  assign command      = s_tdata[1:0];
  assign priority_req = s_tdata[33:2];
  assign payload      = s_tdata[65:34];

  // Take a new word whenever the output register is free or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign empty = (count == '0);
  assign full  = (count == CountWidth'(QueueDepth));

  // Broadcast to the cells; drop inserts when full, pops when empty.
  assign ctrl.insert_en = accept && (command == CmdInsert) && !full;
  assign ctrl.pop_en    = accept && (command == CmdPop) && !empty;
  assign ctrl.new_pri   = priority_req;
  assign ctrl.new_pay   = PayloadWidth'(payload);

  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop_en) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    status_next = StDone;
    if (command == CmdInsert) begin
      if (full) begin
        status_next = StFull;
      end
    end else if (empty) begin
      status_next = StEmpty;
    end
  end

  spq_chain u_chain (
    .clk           (clk),
    .ctrl          (ctrl),
    .count         (count),
    .head_pri_next (head_pri_next),
    .head_pay_next (head_pay_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register: show the head after the step, zero when empty.
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      if (count_next == '0) begin
        head_priority <= '0;
        head_payload  <= '0;
      end else begin
        head_priority <= head_pri_next;
        head_payload  <= DataWidth'(head_pay_next);
      end
    end
  end

  assign m_tdata = {6'b0, head_payload, head_priority, status};

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CountWidth'(QueueDepth))
    else $error("entry count beyond depth");

  a_pop_dec : assert property (@(posedge clk) disable iff (rst)
    (accept && command == CmdPop && !empty) |=> (count == $past(count) - 1'b1))
    else $error("pop did not drop one entry");

  a_full_hold : assert property (@(posedge clk) disable iff (rst)
    (accept && command == CmdInsert && full) |=> (count == CountWidth'(QueueDepth)))
    else $error("insert into full queue changed count");

  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == StEmpty) |-> (head_priority == '0 && head_payload == '0))
    else $error("empty result shows a head entry");

endmodule

[verif/sorted_priority_queue_unit_test.sv]
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test
  import spq_pkg::*;
();

  // Unused command code; the block treats it as a top read.
  localparam logic [CmdWidth-1:0] CmdSpare = 2'd3;

  localparam int CycleLimit  = 400000;
  localparam int PrintBudget = 100;
  localparam int RandomWords = 1700;

  typedef enum int {
    ModeFill,
    ModeMix,
    ModeDrain
  } traffic_mode_t;

  typedef struct packed {
    logic [StatusWidth-1:0]     status;
    logic signed [PriWidth-1:0] pri;
    logic [DataWidth-1:0]       pay;
  } head_word_t;

  // Shadow copy of the sorted row; predicts the head word for each command.
  class queue_shadow;
    logic signed [PriWidth-1:0] pri_row[QueueDepth];
    logic [PayloadWidth-1:0]    pay_row[QueueDepth];
    int                         fill;
    head_word_t                 heads_due[$];
    int                         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return heads_due.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= PrintBudget)
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task apply_command(input logic [CmdWidth-1:0] cmd,
                       input logic signed [PriWidth-1:0] pri,
                       input logic [DataWidth-1:0] pay);
      head_word_t w;
      int         pos;
      int         i;
      w.status = StDone;
      case (cmd)
        CmdInsert: begin
          if (fill >= QueueDepth) begin
            w.status = StFull;
          end else begin
            // A tie with the head lands behind it, not in front.
            if (fill == 0 || pri_row[0] < pri) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < fill && pri_row[pos] > pri)
                pos++;
            end
            for (i = fill; i > pos; i--) begin
              pri_row[i] = pri_row[i-1];
              pay_row[i] = pay_row[i-1];
            end
            pri_row[pos] = pri;
            pay_row[pos] = pay[PayloadWidth-1:0];
            fill++;
          end
        end
        CmdPop: begin
          if (fill == 0) begin
            w.status = StEmpty;
          end else begin
            for (i = 1; i < fill; i++) begin
              pri_row[i-1] = pri_row[i];
              pay_row[i-1] = pay_row[i];
            end
            fill--;
          end
        end
        default: begin
          if (fill == 0)
            w.status = StEmpty;
        end
      endcase
      if (fill == 0) begin
        w.pri = '0;
        w.pay = '0;
      end else begin
        w.pri = pri_row[0];
        w.pay = DataWidth'(pay_row[0]);
      end
      heads_due.push_back(w);
    endtask

    task compare_head(input logic [WordWidth-1:0] word);
      head_word_t w;
      head_word_t got;
      got.status = word[1:0];
      got.pri    = word[33:2];
      got.pay    = word[65:34];
      if (heads_due.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", word));
      end else begin
        w = heads_due.pop_front();
        if (got.status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, w.status));
        if (got.pri !== w.pri)
          report_mismatch($sformatf("head_priority %0d, want %0d", got.pri, w.pri));
        if (got.pay !== w.pay)
          report_mismatch($sformatf("head_payload %h, want %h", got.pay, w.pay));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // [1:0] command, [33:2] priority_req, [65:34] payload, [71:66] zero
  logic [WordWidth-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // [1:0] status, [33:2] head_priority, [65:34] head_payload, [71:66] zero
  logic [WordWidth-1:0] m_tdata;

  queue_shadow shadow;
  bit          calm;        // suppress idling on both sides for a stretch
  int          stall_left;
  int          ready_roll;
  int          cycle_count;

  sorted_priority_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[sorted_priority_queue_unit] ERROR");
      $finish;
    end
  end

  // Receiver side: mostly ready, short stalls often, long stalls rarely.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!calm) begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 25)
          stall_left = $urandom_range(1, 3);
        else if (ready_roll < 29)
          stall_left = $urandom_range(8, 30);
      end
    end
  end

  // Sample both handshakes at the rising edge. Check before noting, so a
  // word accepted at this edge can never be matched by a result at the same
  // edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        shadow.compare_head(m_tdata);
      if (s_tvalid && s_tready)
        shadow.apply_command(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [CmdWidth-1:0] cmd,
                           input logic [PriWidth-1:0] pri,
                           input logic [DataWidth-1:0] pay);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(WordWidth - CmdWidth - PriWidth - DataWidth){1'b0}}, pay, pri, cmd};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (shadow.pending() > 0)
      @(posedge clk);
  endtask

  // Mix of wide random values, tight clusters for ties, and the extremes.
  function automatic logic [PriWidth-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return PriWidth'($signed($urandom_range(0, 8)) - 4);
      6:       return {1'b0, {(PriWidth-1){1'b1}}};
      7:       return {1'b1, {(PriWidth-1){1'b0}}};
      8:       return {1'b0, {(PriWidth-1){1'b1}}} - $urandom_range(0, 3);
      default: return {1'b1, {(PriWidth-1){1'b0}}} + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [DataWidth-1:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CmdWidth-1:0] pick_command(input traffic_mode_t mode);
    int r;
    int ins_cut;
    int top_cut;
    r = $urandom_range(0, 99);
    case (mode)
      ModeFill: begin ins_cut = 75; top_cut = 85; end
      ModeDrain: begin ins_cut = 20; top_cut = 30; end
      default: begin ins_cut = 45; top_cut = 60; end
    endcase
    if (r < ins_cut)
      return CmdInsert;
    if (r < top_cut)
      return CmdTop;
    if (r < 95)
      return CmdPop;
    return CmdSpare;
  endfunction

  initial begin
    traffic_mode_t mode;
    int            sent;
    int            phase_len;
    int            phase_no;

    shadow      = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    calm        = 1'b0;
    stall_left  = 0;
    cycle_count = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue: top, pop and the spare code all report empty.
    send_word(CmdTop, '0, '0);
    send_word(CmdPop, '1, '1);
    send_word(CmdSpare, '0, '0);
    // First insert becomes the head; a tie with the head lands behind it.
    send_word(CmdInsert, 32'sd5, 32'h0000_0011);
    send_word(CmdInsert, 32'sd5, 32'h0000_0022);
    // Greater than the head goes in front.
    send_word(CmdInsert, 32'sd9, 32'h0000_0033);
    send_word(CmdInsert, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(CmdInsert, 32'h8000_0000, 32'h0000_0000);
    send_word(CmdInsert, 32'sd0, 32'hA5A5_5A5A);
    send_word(CmdInsert, -32'sd1, 32'h5A5A_A5A5);
    // Tie in the middle of the row.
    send_word(CmdInsert, 32'sd5, 32'h0000_0044);
    send_word(CmdTop, '0, '0);
    send_word(CmdSpare, '1, '1);
    // Drain everything and pop once more on empty.
    repeat (9) send_word(CmdPop, '0, '0);
    drain_results();

    // Random traffic in phases: fill to the top (exercises full drops),
    // churn, and drain to empty, with calm stretches now and then.
    sent     = 0;
    phase_no = 0;
    while (sent < RandomWords) begin
      case (phase_no % 4)
        0: mode = ModeFill;
        1: mode = ModeMix;
        2: mode = ModeDrain;
        default: mode = traffic_mode_t'($urandom_range(0, 2));
      endcase
      calm      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 200);
      repeat (phase_len) begin
        send_word(pick_command(mode), pick_priority(), pick_payload());
        sent++;
      end
      calm = 1'b0;
      if (phase_no == 0 || $urandom_range(0, 2) == 0)
        drain_results();
      phase_no++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (shadow.errors == 0)
      $display("[sorted_priority_queue_unit] OK");
    else
      $display("[sorted_priority_queue_unit] ERROR");
    $finish;
  end

endmodule
